@@ sv/hdr_tonemap_to_srgb8_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the HDR tone-map block
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef HDR_TONEMAP_TO_SRGB8_TOP_ASSERT_SVH
`define HDR_TONEMAP_TO_SRGB8_TOP_ASSERT_SVH
`ifndef SYNTH
`define HT2S_AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define HT2S_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define HT2S_AST_SAME(lbl, clk, rst_n, ante, cons)
`define HT2S_AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ht2s_pkg.sv @@
// ----------------------------------------------------------------------------
// ht2s_pkg
// Types, constants and the sRGB threshold table of the tone-map block.
// ----------------------------------------------------------------------------
`default_nettype none
package ht2s_pkg;

    typedef struct packed {
        logic signed [31:0] red_in;
        logic signed [31:0] green_in;
        logic signed [31:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic [23:0] exposure_gain;
        logic        tonemap_enable;
        logic        srgb_enable;
    } t_cfg;

    // Side data that travels beside the divider
    typedef struct packed {
        logic [16:0] vlin;
        logic        big;
    } t_div_side;

    typedef enum logic [1:0] {
        REG_EXPOSURE = 2'd0,
        REG_TONEMAP  = 2'd1,
        REG_SRGB     = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    localparam logic [23:0] GAIN_RST  = 24'd65536;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam int          PROD_W    = 55;
    localparam int          NUM_W     = 46;
    localparam int          DEN_W     = 47;
    localparam int          QUO_BITS  = 17;
    localparam int          CODE_BITS = 8;

    typedef logic [16:0] t_thr_tab [256];

    // Smallest Q16 value whose exact sRGB encoding reaches each code midpoint
    function automatic t_thr_tab f_build_thr();
        t_thr_tab     tab;
        logic [319:0] lhs_c;
        logic [319:0] rhs_k;
        logic [319:0] lhs;
        logic [319:0] vp;
        logic [63:0]  l64;
        logic [63:0]  r64;
        logic         reach;
        int           k;
        int           i;
        int           lo;
        int           hi;
        int           mid;
        tab[0] = 17'd0;
        lhs_c = 320'd1;
        for (i = 0; i < 12; i++) begin
            lhs_c = lhs_c * 320'd53805;
        end
        for (k = 1; k < 256; k++) begin
            rhs_k = 320'd1;
            for (i = 0; i < 12; i++) begin
                rhs_k = rhs_k * 320'(200 * k + 2705);
            end
            rhs_k = rhs_k << 80;
            lo = 0;
            hi = 65536;
            while (hi - lo > 1) begin
                mid = lo + (hi - lo) / 2;
                if (64'(mid) * 64'd10000000 <= 64'd31308 * 64'd65536) begin
                    l64   = 64'd658920 * 64'(mid);
                    r64   = 64'(2 * k - 1) * 64'd6553600;
                    reach = (l64 >= r64);
                end else begin
                    vp  = 320'(mid);
                    lhs = lhs_c;
                    for (i = 0; i < 5; i++) begin
                        lhs = lhs * vp;
                    end
                    reach = (lhs >= rhs_k);
                end
                if (reach) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
            tab[k] = 17'(hi);
        end
        return tab;
    endfunction

    localparam t_thr_tab THR_TAB = f_build_thr();

endpackage
`default_nettype wire

@@ sv/ht2s_div.sv @@
// ----------------------------------------------------------------------------
// ht2s_div
// Pipelined restoring divider: one quotient bit per stage, 17 stages.
// ----------------------------------------------------------------------------
`default_nettype none
module ht2s_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [45:0]              i_num,
    input  wire logic [46:0]              i_den,
    input  wire ht2s_pkg::t_div_side      i_side,
    output logic                          o_valid,
    output logic [16:0]                   o_quo,
    output ht2s_pkg::t_div_side           o_side
);
    import ht2s_pkg::*;

    localparam int NS = QUO_BITS;

    logic [DEN_W-1:0]    r_rem  [0:NS];
    logic [DEN_W-1:0]    r_den  [0:NS];
    logic [QUO_BITS-1:0] r_quo  [0:NS];
    t_div_side           r_side [0:NS];
    logic                r_vld  [0:NS];
    logic                r_lsb;

    // Load: quotient is known to fit 17 bits, so start from num/2
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DEN_W'(i_num >> 1);
        r_den[0]  <= i_den;
        r_quo[0]  <= '0;
        r_side[0] <= i_side;
        r_lsb     <= i_num[0];
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [DEN_W:0] w_trial;
        logic           w_ge;
        if (j == 0) begin : g_first
            assign w_trial = {r_rem[j], r_lsb};
        end else begin : g_rest
            assign w_trial = {r_rem[j], 1'b0};
        end
        assign w_ge = (w_trial >= {1'b0, r_den[j]});

        // Subtract where the divisor fits, shift in the quotient bit
        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= w_ge ? DEN_W'(w_trial - {1'b0, r_den[j]}) : w_trial[DEN_W-1:0];
            r_den[j+1]  <= r_den[j];
            r_quo[j+1]  <= {r_quo[j][QUO_BITS-2:0], w_ge};
            r_side[j+1] <= r_side[j];
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    assign o_valid = r_vld[NS];
    assign o_quo   = r_quo[NS];
    assign o_side  = r_side[NS];

endmodule
`default_nettype wire

@@ sv/ht2s_enc.sv @@
// ----------------------------------------------------------------------------
// ht2s_enc
// 8-bit code encoder: pipelined sRGB threshold search or linear rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module ht2s_enc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [16:0] i_val,
    input  wire logic        i_srgb,
    output logic             o_valid,
    output logic [7:0]       o_code
);
    import ht2s_pkg::*;

    logic [16:0]          r_val  [0:CODE_BITS];
    logic [CODE_BITS-1:0] r_code [0:CODE_BITS];
    logic [CODE_BITS-1:0] r_lin  [0:CODE_BITS];
    logic                 r_srgb [0:CODE_BITS];
    logic                 r_vld  [0:CODE_BITS];
    logic [24:0]          w_lin;

    // Linear code: round(255 v) in Q16
    assign w_lin = 25'(i_val) * 25'd255 + 25'd32768;

    always_ff @(posedge i_clk) begin
        r_val[0]  <= i_val;
        r_code[0] <= '0;
        r_lin[0]  <= w_lin[23:16];
        r_srgb[0] <= i_srgb;
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar b = 0; b < CODE_BITS; b++) begin : g_step
        logic [CODE_BITS-1:0] w_cand;
        assign w_cand = r_code[b] | CODE_BITS'(1 << (CODE_BITS - 1 - b));

        // Take the candidate bit where the value reaches its threshold
        always_ff @(posedge i_clk) begin
            r_val[b+1]  <= r_val[b];
            r_code[b+1] <= (r_val[b] >= THR_TAB[w_cand]) ? w_cand : r_code[b];
            r_lin[b+1]  <= r_lin[b];
            r_srgb[b+1] <= r_srgb[b];
            if (!i_rst_n) begin
                r_vld[b+1] <= 1'b0;
            end else begin
                r_vld[b+1] <= r_vld[b];
            end
        end
    end

    assign o_valid = r_vld[CODE_BITS];
    assign o_code  = r_srgb[CODE_BITS] ? r_code[CODE_BITS] : r_lin[CODE_BITS];

endmodule
`default_nettype wire

@@ sv/ht2s_lane.sv @@
// ----------------------------------------------------------------------------
// ht2s_lane
// One colour channel: exposure, ACES curve, clamp and code encoding.
// ----------------------------------------------------------------------------
`default_nettype none
module ht2s_lane #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_sample,
    input  wire ht2s_pkg::t_cfg     i_cfg,
    output logic                    o_valid,
    output logic [7:0]              o_code
);
    import ht2s_pkg::*;

    localparam int F = INPUT_FRAC_BITS;

    logic [PROD_W-1:0] r_prod;
    logic              r_v1;
    logic [18:0]       r_v19;
    logic              r_big;
    logic [16:0]       r_vlin;
    logic              r_v2;
    logic [26:0]       r_a;
    logic [26:0]       r_b;
    logic [18:0]       r_v19b;
    t_div_side         r_side3;
    logic              r_v3;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    t_div_side         r_side4;
    logic              r_v4;
    logic              w_dvld;
    logic [16:0]       w_quo;
    t_div_side         w_dside;
    logic [16:0]       r_sel;
    logic              r_v5;
    logic [PROD_W-1:0] w_prod;
    logic              w_over;

    // Exposure gain; non-positive samples give zero
    assign w_prod = i_sample[31] ? '0 :
                    PROD_W'(i_sample[30:0]) * PROD_W'(i_cfg.exposure_gain);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    // Truncate to Q16 and form the saturation flags
    assign w_over = (|r_prod[PROD_W-1:F+17]) || (r_prod[F+16] && (|r_prod[F+15:F]));

    always_ff @(posedge i_clk) begin
        r_v19 <= r_prod[F+18:F];
        r_big <= |r_prod[PROD_W-1:F+19];
        r_vlin <= w_over ? ONE_Q16 : r_prod[F+16:F];
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    // Inner terms of the rational curve
    always_ff @(posedge i_clk) begin
        r_a          <= 27'(r_v19) * 27'd251 + 27'd196608;
        r_b          <= 27'(r_v19) * 27'd243 + 27'd3866624;
        r_v19b       <= r_v19;
        r_side3.vlin <= r_vlin;
        r_side3.big  <= r_big;
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    // Numerator and denominator of the curve
    always_ff @(posedge i_clk) begin
        r_num   <= NUM_W'(r_v19b) * NUM_W'(r_a);
        r_den   <= DEN_W'(r_v19b) * DEN_W'(r_b) + (DEN_W'(14) << 32);
        r_side4 <= r_side3;
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    ht2s_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side4),
        .o_valid (w_dvld),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    // Pick curve or plain clamp
    always_ff @(posedge i_clk) begin
        if (!i_cfg.tonemap_enable) begin
            r_sel <= w_dside.vlin;
        end else if (w_dside.big || (w_quo > ONE_Q16)) begin
            r_sel <= ONE_Q16;
        end else begin
            r_sel <= w_quo;
        end
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= w_dvld;
        end
    end

    ht2s_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v5),
        .i_val   (r_sel),
        .i_srgb  (i_cfg.srgb_enable),
        .o_valid (o_valid),
        .o_code  (o_code)
    );

endmodule
`default_nettype wire

@@ sv/hdr_tonemap_to_srgb8_top.sv @@
// A result strobes on o_valid once the pixel taken on start has passed every lane stage.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Latency is set by the 17-stage divider and 8-stage threshold search per lane.
// Reset (synchronous, active low) clears all valid bits and restores the
// registers: gain 1.0, tone curve off, sRGB on. The receiver cannot stall.
// ----------------------------------------------------------------------------
// hdr_tonemap_to_srgb8_top
// HDR linear RGB pixel to 8-bit display codes over three channel lanes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hdr_tonemap_to_srgb8_top_assert.svh"
module hdr_tonemap_to_srgb8_top #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ht2s_pkg::t_pix_in i_pixel,
    output logic                   o_valid,
    output ht2s_pkg::t_pix_out     o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import ht2s_pkg::*;

    logic        r_valid;
    t_pix_out    r_result;
    t_cfg        w_cfg;
    logic [23:0] r_exposure_gain;
    logic        r_tonemap_enable;
    logic        r_srgb_enable;
    t_reg_idx    w_idx;
    logic        w_wr;
    logic        w_take;
    logic [2:0]  w_lane_vld;
    logic [7:0]  w_code [0:2];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_take = start && !busy;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Configuration transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure_gain  <= GAIN_RST;
            r_tonemap_enable <= 1'b0;
            r_srgb_enable    <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_EXPOSURE: r_exposure_gain  <= pwdata[23:0];
                REG_TONEMAP:  r_tonemap_enable <= pwdata[0];
                REG_SRGB:     r_srgb_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_EXPOSURE: prdata = {8'd0, r_exposure_gain};
            REG_TONEMAP:  prdata = {31'd0, r_tonemap_enable};
            REG_SRGB:     prdata = {31'd0, r_srgb_enable};
            default:      prdata = 32'd0;
        endcase
    end

    assign w_cfg.exposure_gain  = r_exposure_gain;
    assign w_cfg.tonemap_enable = r_tonemap_enable;
    assign w_cfg.srgb_enable    = r_srgb_enable;

    ht2s_lane #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_lane_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_take),
        .i_sample (i_pixel.red_in), .i_cfg (w_cfg),
        .o_valid (w_lane_vld[0]), .o_code (w_code[0])
    );
    ht2s_lane #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_lane_g (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_take),
        .i_sample (i_pixel.green_in), .i_cfg (w_cfg),
        .o_valid (w_lane_vld[1]), .o_code (w_code[1])
    );
    ht2s_lane #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_lane_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_take),
        .i_sample (i_pixel.blue_in), .i_cfg (w_cfg),
        .o_valid (w_lane_vld[2]), .o_code (w_code[2])
    );

    // Merge lane codes into one result transaction
    always_ff @(posedge i_clk) begin
        r_result.red_out   <= w_code[0];
        r_result.green_out <= w_code[1];
        r_result.blue_out  <= w_code[2];
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_lane_vld[0];
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `HT2S_AST_SAME(a_lane_sync, i_clk, i_rst_n, w_lane_vld[0], w_lane_vld[1] && w_lane_vld[2])
    `HT2S_AST_NEXT(a_merge_out, i_clk, i_rst_n, w_lane_vld[0], o_valid)
    `HT2S_AST_NEXT(a_tm_write, i_clk, i_rst_n, w_wr && (w_idx == REG_TONEMAP), r_tonemap_enable == $past(pwdata[0]))

endmodule
`default_nettype wire

@@ sim/hdr_tonemap_to_srgb8_checker.sv @@
// ----------------------------------------------------------------------------
// hdr_tonemap_to_srgb8_checker
// Watches the pixel, result and register channels of the tone-map block,
// predicts each display code triple and compares it with the result.
// ----------------------------------------------------------------------------
`default_nettype none
module hdr_tonemap_to_srgb8_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire ht2s_pkg::t_pix_in  i_pixel,
    input  wire logic               o_valid,
    input  wire ht2s_pkg::t_pix_out o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output int                      fail_count,
    output int                      pending
);
    import ht2s_pkg::*;

    localparam int FRAC = 16;

    logic [23:0] gain;
    logic        aces_on;
    logic        srgb_on;
    logic [16:0] code_edge [256];
    t_pix_out    codes_due [$];

    // Lowest Q16 level whose exact sRGB encoding reaches the midpoint below code k
    function automatic logic [16:0] srgb_threshold(int k);
        logic [319:0] base;
        logic [319:0] target;
        logic [319:0] pw;
        int           lo;
        int           hi;
        int           mid;
        int           n;
        bit           hit;
        base   = 320'd1;
        target = 320'd1;
        for (n = 0; n < 12; n++) begin
            base   = base * 320'd53805;
            target = target * 320'(200 * k + 2705);
        end
        target = target << 80;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (64'(mid) * 64'd10000000 <= 64'd2051801088) begin
                hit = (64'd658920 * 64'(mid)) >= (64'(2 * k - 1) * 64'd6553600);
            end else begin
                pw = base;
                for (n = 0; n < 5; n++) begin
                    pw = pw * 320'(mid);
                end
                hit = (pw >= target);
            end
            if (hit) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        return 17'(hi);
    endfunction

    // Exposure, clamp or filmic curve, then quantise one channel
    function automatic logic [7:0] display_code(logic signed [31:0] sample);
        logic [63:0] lvl;
        logic [63:0] num;
        logic [63:0] den;
        int          k;
        int          cnt;
        if (sample <= 0 || gain == 24'd0) begin
            lvl = 64'd0;
        end else begin
            lvl = (64'(unsigned'(sample)) * 64'(gain)) >> FRAC;
        end
        if (aces_on) begin
            if (lvl >= 64'd524288) begin
                lvl = 64'd65536;
            end else begin
                num = lvl * (64'd251 * lvl + 64'd196608);
                den = lvl * (64'd243 * lvl + 64'd3866624) + 64'd60129542144;
                lvl = (num << 16) / den;
                if (lvl > 64'd65536) lvl = 64'd65536;
            end
        end else if (lvl > 64'd65536) begin
            lvl = 64'd65536;
        end
        if (srgb_on) begin
            cnt = 0;
            for (k = 1; k < 256; k++) begin
                if (lvl >= 64'(code_edge[k])) cnt++;
            end
            return 8'(cnt);
        end
        return 8'((64'd255 * lvl + 64'd32768) >> 16);
    endfunction

    initial begin
        int k;
        fail_count = 0;
        pending    = 0;
        code_edge[0] = 17'd0;
        for (k = 1; k < 256; k++) begin
            code_edge[k] = srgb_threshold(k);
        end
    end

    // Track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        t_pix_out exp_pix;
        if (!i_rst_n) begin
            gain    <= GAIN_RST;
            aces_on <= 1'b0;
            srgb_on <= 1'b1;
            codes_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_EXPOSURE: gain    <= pwdata[23:0];
                    REG_TONEMAP:  aces_on <= pwdata[0];
                    REG_SRGB:     srgb_on <= pwdata[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                exp_pix.red_out   = display_code(i_pixel.red_in);
                exp_pix.green_out = display_code(i_pixel.green_in);
                exp_pix.blue_out  = display_code(i_pixel.blue_in);
                codes_due.push_back(exp_pix);
            end
            if (o_valid) begin
                if (codes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", o_result);
                end else begin
                    exp_pix = codes_due.pop_front();
                    if (exp_pix !== o_result) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected r%0d g%0d b%0d got r%0d g%0d b%0d",
                                exp_pix.red_out, exp_pix.green_out, exp_pix.blue_out,
                                o_result.red_out, o_result.green_out, o_result.blue_out);
                    end
                end
            end
        end
        // Publish the number of outstanding results
        pending = codes_due.size();
    end
endmodule
`default_nettype wire

@@ sim/hdr_tonemap_to_srgb8_top_test.sv @@
// ----------------------------------------------------------------------------
// hdr_tonemap_to_srgb8_top_test
// Drives pixels and register writes into the tone-map block over several
// exposure and curve settings; the checker beside it judges every result.
// ----------------------------------------------------------------------------
`default_nettype none
module hdr_tonemap_to_srgb8_top_test;
    import ht2s_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_pix_in     i_pixel = '0;
    logic        o_valid;
    t_pix_out    o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          allow_idle = 1'b1;

    hdr_tonemap_to_srgb8_top DUT (.*);

    hdr_tonemap_to_srgb8_checker u_checker (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("FAIL hdr_tonemap_to_srgb8_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One APB write: setup then access
    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_settings(logic [23:0] g, bit aces, bit srgb);
        reg_write(REG_EXPOSURE, {8'h0, g});
        reg_write(REG_TONEMAP, {31'h0, aces});
        reg_write(REG_SRGB, {31'h0, srgb});
    endtask

    // Hold the transaction until the block takes it, idling now and then;
    // called at a falling edge so that transactions can follow back to back
    task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        while (allow_idle && $urandom_range(0, 99) < 15) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_pixel = {r, g, b};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Drain every outstanding result, then let the pipeline settle
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0002_0000);
            2: return -$urandom_range(1, 32'h7FFF_FFFF);
            3: return $urandom_range(0, 32'h0001_0000);
            4: return $urandom_range(32'h0007_0000, 32'h0100_0000);
            default: return $urandom_range(0, 32'h0000_0800);
        endcase
    endfunction

    task automatic random_burst(int n);
        repeat (n) send_pixel(pick_sample(), pick_sample(), pick_sample());
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero, negatives, one, extremes, tiny values near sRGB knee
        send_pixel(32'd0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_pixel(32'h7FFF_FFFF, 32'd1, 32'h0001_0000);
        send_pixel(32'h0000_FFFF, 32'h0001_0001, 32'h0000_00CD);
        send_pixel(32'h0000_00CE, 32'h0000_8000, 32'h0000_0080);
        drain();
        apply_settings(24'd65536, 1'b1, 1'b1);
        send_pixel(32'd0, 32'h0008_0000, 32'h0007_FFFF);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_pixel(32'h0000_4000, 32'd1, 32'h0003_0000);
        drain();
        apply_settings(24'd0, 1'b0, 1'b0);
        send_pixel(32'h7FFF_FFFF, 32'h0001_0000, 32'd1);
        drain();
        apply_settings(24'hFF_FFFF, 1'b1, 1'b0);
        send_pixel(32'h7FFF_FFFF, 32'd1, 32'h0000_0100);
        send_pixel(32'h8000_0000, 32'h0000_0010, 32'h0000_0001);
        drain();
        apply_settings(24'd1, 1'b0, 1'b1);
        send_pixel(32'h7FFF_FFFF, 32'h0100_0000, 32'h0001_0000);
        drain();

        // Random phases across settings; one phase runs without idling
        apply_settings(24'd65536, 1'b0, 1'b1);
        random_burst(200);
        drain();
        apply_settings(24'd65536, 1'b1, 1'b1);
        allow_idle = 1'b0;
        random_burst(200);
        allow_idle = 1'b1;
        drain();
        apply_settings(24'hFF_FFFF, 1'b0, 1'b0);
        random_burst(150);
        drain();
        apply_settings(24'd0, 1'b1, 1'b0);
        random_burst(50);
        drain();
        repeat (6) begin
            apply_settings(24'($urandom_range(0, 24'h04_0000)),
                           1'($urandom), 1'($urandom));
            random_burst(100);
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS hdr_tonemap_to_srgb8_top");
        end else begin
            $display("FAIL hdr_tonemap_to_srgb8_top");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ hdr_tonemap_to_srgb8_top.f @@
+incdir+sv
sv/ht2s_pkg.sv
sv/ht2s_div.sv
sv/ht2s_enc.sv
sv/ht2s_lane.sv
sv/hdr_tonemap_to_srgb8_top.sv
sim/hdr_tonemap_to_srgb8_checker.sv
sim/hdr_tonemap_to_srgb8_top_test.sv
